// ===== design/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, codes and request structs for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    // Storage shape
    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Port field widths
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int OFFSET_W = 10;
    localparam int ELEM_W   = 32;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    // Width used to compare an offset with the element count
    localparam int CMP_W = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_READ       = 3'd4,
        CMD_CLEAR      = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Store access issued for one command
    typedef struct packed {
        logic                  we;
        logic [PTR_W-1:0]      waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [PTR_W-1:0]      raddr;
    } t_ram_req;

    // Result fields known at issue time
    typedef struct packed {
        logic             rd;
        logic [CNT_W-1:0] count;
        t_status          status;
    } t_meta;

    // Circular add of two positions below DEPTH
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PTR_W + 1)'(DEPTH)) begin
            s = s - (PTR_W + 1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

// ===== design/dq_ram.sv =====
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, hold when idle
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl
// Front position and element count; decodes a command into a store access
// and the result fields that do not depend on read data.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [dq_pkg::CMD_W-1:0]     i_command,
    input  logic [dq_pkg::VALUE_W-1:0]   i_value,
    input  logic [dq_pkg::OFFSET_W-1:0]  i_offset,
    output dq_pkg::t_ram_req             o_req,
    output dq_pkg::t_meta                o_meta
);
    import dq_pkg::*;

    logic [PTR_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] cnt_m1;
    logic [PTR_W-1:0] front_inc, front_dec, back_pos, last_pos, read_pos;
    logic             is_full, is_empty, in_range;
    logic [DATA_WIDTH-1:0] wdata;

    // Derived positions
    assign cnt_m1    = r_count - CNT_W'(1);
    assign front_inc = wrap_add(r_front, PTR_W'(1));
    assign front_dec = (r_front == '0) ? PTR_W'(DEPTH - 1) : r_front - PTR_W'(1);
    assign back_pos  = wrap_add(r_front, r_count[PTR_W-1:0]);
    assign last_pos  = wrap_add(r_front, cnt_m1[PTR_W-1:0]);
    assign read_pos  = wrap_add(r_front, PTR_W'(i_offset));
    assign is_full   = (r_count == CNT_W'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign in_range  = (CMP_W'(i_offset) < CMP_W'(r_count));
    assign wdata     = DATA_WIDTH'($unsigned(i_value));

    // Decode command
    always_comb begin
        n_front      = r_front;
        n_count      = r_count;
        o_req.we     = 1'b0;
        o_req.waddr  = back_pos;
        o_req.wdata  = wdata;
        o_req.re     = 1'b0;
        o_req.raddr  = r_front;
        o_meta.rd    = 1'b0;
        o_meta.status = ST_DONE;
        case (t_cmd'(i_command))
            CMD_PUSH_BACK: begin
                if (is_full) begin
                    o_meta.status = ST_FULL;
                end else begin
                    o_req.we = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            CMD_PUSH_FRONT: begin
                if (is_full) begin
                    o_meta.status = ST_FULL;
                end else begin
                    o_req.we    = 1'b1;
                    o_req.waddr = front_dec;
                    n_front     = front_dec;
                    n_count     = r_count + CNT_W'(1);
                end
            end
            CMD_POP_BACK: begin
                if (is_empty) begin
                    o_meta.status = ST_EMPTY;
                end else begin
                    o_req.re    = 1'b1;
                    o_req.raddr = last_pos;
                    o_meta.rd   = 1'b1;
                    n_count     = cnt_m1;
                end
            end
            CMD_POP_FRONT: begin
                if (is_empty) begin
                    o_meta.status = ST_EMPTY;
                end else begin
                    o_req.re  = 1'b1;
                    o_meta.rd = 1'b1;
                    n_front   = front_inc;
                    n_count   = cnt_m1;
                end
            end
            CMD_READ: begin
                if (!in_range) begin
                    o_meta.status = ST_RANGE;
                end else begin
                    o_req.re    = 1'b1;
                    o_req.raddr = read_pos;
                    o_meta.rd   = 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
        o_meta.count = n_count;
        // Gate side effects on the transfer
        o_req.we = o_req.we & i_fire;
        o_req.re = o_req.re & i_fire;
    end

    // Hold pointer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count above capacity");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_command == CMD_PUSH_BACK || i_command == CMD_PUSH_FRONT)
            && o_meta.status == ST_DONE
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("accepted push did not grow the count");

    a_no_write_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_meta.status != ST_DONE |-> !o_req.we && !o_req.re)
        else $error("rejected command touched the store");
`endif

endmodule

// ===== design/double_ended_queue_top.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue over a circular single-port-pair store.
// A command is registered in the issue stage, then in the output register.
// Throughput: one command per cycle when not stalled, set by its store access.
// Reset: synchronous active low; clears front position, count and valids.
// The element store is not cleared; only held entries are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [dq_pkg::CMD_W-1:0]            i_command,
    input  logic signed [dq_pkg::VALUE_W-1:0]   i_value,
    input  logic [dq_pkg::OFFSET_W-1:0]         i_offset,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [dq_pkg::ELEM_W-1:0]    o_element,
    output logic [dq_pkg::COUNT_W-1:0]          o_count,
    output logic [dq_pkg::STATUS_W-1:0]         o_status
);
    import dq_pkg::*;

    t_ram_req              req;
    t_meta                 meta;
    logic                  fire;
    logic                  s1_move;
    logic [DATA_WIDTH-1:0] rdata;

    logic                  r_s1_valid;
    t_meta                 r_s1_meta;
    logic                  r_out_valid;
    logic [ELEM_W-1:0]     r_element;
    logic [COUNT_W-1:0]    r_count;
    logic [STATUS_W-1:0]   r_status;

    // Handshake: issue stage moves when output register is empty or drains
    assign s1_move = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !s1_move;
    assign fire    = i_valid && !o_stall;

    dq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_command (i_command),
        .i_value   (i_value),
        .i_offset  (i_offset),
        .o_req     (req),
        .o_meta    (meta)
    );

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (req.we),
        .i_waddr (req.waddr),
        .i_wdata (req.wdata),
        .i_re    (req.re),
        .i_raddr (req.raddr),
        .o_rdata (rdata)
    );

    // Valid bits for issue stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload: capture metadata on transfer, merge read data on advance
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1_meta <= meta;
        end
        if (s1_move && r_s1_valid) begin
            r_element <= r_s1_meta.rd ? ELEM_W'(rdata) : '0;
            r_count   <= COUNT_W'(r_s1_meta.count);
            r_status  <= r_s1_meta.status;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_element = r_element;
    assign o_count   = r_count;
    assign o_status  = r_status;

`ifndef SYNTHESIS
    a_stall_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid && r_out_valid)
        else $error("input stalled with free pipeline");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_DONE |-> o_element == '0)
        else $error("rejected command returned nonzero element");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_count == COUNT_W'(DEPTH))
        else $error("full rejection with count below capacity");
`endif

endmodule
